// ===== sv/abf_pkg.sv =====
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types and constants for the byte framer: frame phases, register
// indexes, byte codes and the command item that the front passes to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package abf_pkg;

   localparam int RX_W       = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [7:0] CODE_SYN       = 8'h16;
   localparam logic [7:0] CODE_START     = 8'h01;
   localparam logic [7:0] CODE_END_TEXT  = 8'h83;
   localparam logic [7:0] CODE_END_BLOCK = 8'h97;
   localparam logic [7:0] CODE_RUB       = 8'h7F;
   localparam logic [7:0] CODE_ONES      = 8'hFF;
   localparam logic [7:0] CODE_ZEROS     = 8'h00;
   localparam logic [7:0] CODE_PLUS      = 8'hAB;
   localparam logic [7:0] CODE_STAR      = 8'h2A;

   localparam logic [6:0] RST_PREAMBLE_MIN_RUN = 7'd12;
   localparam logic [4:0] RST_INVERT_RUN       = 5'd10;
   localparam logic [8:0] RST_MAX_TEXT_LEN     = 9'd240;
   localparam logic [6:0] RST_MIN_HEADER_LEN   = 7'd13;

   localparam logic signed [7:0] RUN_MAX = 8'sd127;
   localparam logic [3:0]        BITS_FULL = 4'd8;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_SYNC = 3'd1,
      PH_SOH  = 3'd2,
      PH_TEXT = 3'd3,
      PH_CRC1 = 3'd4,
      PH_CRC2 = 3'd5,
      PH_TAIL = 3'd6
   } abf_phase_type;

   typedef enum logic [1:0] {
      CSR_PREAMBLE_MIN_RUN = 2'd0,
      CSR_INVERT_RUN       = 2'd1,
      CSR_MAX_TEXT_LEN     = 2'd2,
      CSR_MIN_HEADER_LEN   = 2'd3
   } abf_csr_type;

   typedef enum logic [1:0] {
      KIND_TEXT = 2'd0,
      KIND_CRC1 = 2'd1,
      KIND_CRC2 = 2'd2
   } abf_kind_type;

   typedef struct packed {
      logic         valid;
      logic [7:0]   data;
      abf_kind_type kind;
      logic         start;
      logic         done;
      logic         abort;
   } abf_slot_type;

   // one accepted byte: shared fields plus up to three result slots
   typedef struct packed {
      logic [3:0]         nbits;
      logic               flip;
      logic [1:0]         cnt;
      abf_slot_type [2:0] slot;
   } abf_cmd_type;

endpackage

`default_nettype wire

// ===== sv/abf_front.sv =====
// ----------------------------------------------------------------------------
// abf_front
// Takes received bytes, runs preamble hunting, bit-slip, sync and text
// framing, and turns each byte into one command item for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_front #(
   parameter int TEXT_LIMIT = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [abf_pkg::RX_W-1:0]           req_tdata,
   input  wire logic                               csr_we,
   input  wire logic [abf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [abf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output      logic                               push,
   output      abf_pkg::abf_cmd_type               cmd,
   input  wire logic                               q_full
);
   import abf_pkg::*;

   localparam int TCW  = $clog2(TEXT_LIMIT + 1);
   localparam int CMPW = (TCW > 9) ? TCW : 9;

   logic [6:0]         pmr_ff;
   logic [4:0]         inv_ff;
   logic [8:0]         mtl_ff;
   logic [6:0]         mhl_ff;

   abf_phase_type      phase_ff, phase_in;
   logic signed [7:0]  rc_ff, rc_in;
   logic [TCW-1:0]     tc_ff, tc_in;
   logic [1:0]         fill_ff, fill_in;
   logic [7:0]         d0_ff, d0_in, d1_ff, d1_in;

   logic [7:0]         rx;
   logic               accept;
   logic [3:0]         slip_len;
   logic               pre_ok, sync_ok, is_end, del_ok, limit_hit, del_len_ok;
   logic [CMPW-1:0]    limit_w;
   logic signed [7:0]  rc_dec, neg_inv;
   logic               to_hunt;
   abf_cmd_type        cmd_in;

   assign rx         = req_tdata;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;
   assign cmd        = cmd_in;

   // position of the lowest zero bit, plus one
   always_comb begin
      slip_len = BITS_FULL;
      for (int i = 7; i >= 0; i--) begin
         if (!rx[i]) slip_len = 4'(i + 1);
      end
   end

   assign pre_ok  = (rc_ff >= $signed({1'b0, pmr_ff})) && (rx != CODE_ONES);
   assign rc_dec  = rc_ff - 8'sd1;
   assign neg_inv = -$signed({3'b000, inv_ff});
   assign is_end  = (rx == CODE_END_TEXT) || (rx == CODE_END_BLOCK);

   always_comb begin
      case (rc_ff)
         8'sd0:         sync_ok = (rx == CODE_PLUS);
         8'sd1:         sync_ok = (rx == CODE_STAR);
         8'sd2, 8'sd3:  sync_ok = (rx == CODE_SYN);
         default:       sync_ok = 1'b0;
      endcase
   end

   assign limit_w    = (CMPW'(mtl_ff) > CMPW'(TEXT_LIMIT)) ? CMPW'(TEXT_LIMIT) : CMPW'(mtl_ff);
   assign limit_hit  = CMPW'(tc_ff) >= limit_w;
   assign del_len_ok = ((CMPW+1)'(tc_ff) + (CMPW+1)'(1)) >=
                       ((CMPW+1)'(mhl_ff) + (CMPW+1)'(3));
   assign del_ok     = (rx == CODE_RUB) && del_len_ok && (fill_ff == 2'd2);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (pre_ok) begin
               if (slip_len != 4'd3)        phase_in = PH_SYNC;
               else if (rx == CODE_PLUS)    phase_in = PH_SYNC;
               else                         phase_in = PH_HUNT;
            end
         end
         PH_SYNC: begin
            if (!sync_ok)                   phase_in = PH_HUNT;
            else if (rc_ff == 8'sd3)        phase_in = PH_SOH;
         end
         PH_SOH:  phase_in = (rx == CODE_START) ? PH_TEXT : PH_HUNT;
         PH_TEXT: begin
            if (limit_hit)                  phase_in = PH_HUNT;
            else if (is_end)                phase_in = PH_CRC1;
            else if (del_ok)                phase_in = PH_HUNT;
         end
         PH_CRC1: phase_in = PH_CRC2;
         PH_CRC2: phase_in = PH_TAIL;
         PH_TAIL: phase_in = PH_HUNT;
         default: phase_in = PH_HUNT;
      endcase
   end

   // counters, delay line and command item
   always_comb begin
      rc_in   = rc_ff;
      tc_in   = tc_ff;
      fill_in = fill_ff;
      d0_in   = d0_ff;
      d1_in   = d1_ff;
      to_hunt = 1'b0;
      cmd_in        = '0;
      cmd_in.nbits  = BITS_FULL;
      cmd_in.cnt    = 2'd1;
      unique case (phase_ff)
         PH_HUNT: begin
            if (pre_ok) begin
               rc_in = 8'sd0;
               if (slip_len < 4'd3) begin
                  cmd_in.nbits = {3'b011, rx[0]};
                  rc_in        = 8'sd1;
               end else if (slip_len > 4'd3) begin
                  cmd_in.nbits = slip_len - 4'd3;
               end else if (rx == CODE_PLUS) begin
                  rc_in = 8'sd1;
               end else begin
                  to_hunt = 1'b1;
               end
            end else if (rx == CODE_ZEROS) begin
               if (rc_dec <= neg_inv) begin
                  cmd_in.flip = 1'b1;
                  rc_in       = -rc_dec;
               end else begin
                  rc_in = rc_dec;
               end
            end else if (rx == CODE_ONES) begin
               if (rc_ff < RUN_MAX) rc_in = rc_ff + 8'sd1;
            end else begin
               rc_in = 8'sd0;
            end
         end
         PH_SYNC: begin
            if (sync_ok) rc_in = rc_ff + 8'sd1;
            else         to_hunt = 1'b1;
         end
         PH_SOH: begin
            if (rx == CODE_START) begin
               tc_in               = '0;
               fill_in             = 2'd0;
               cmd_in.slot[0].start = 1'b1;
            end else begin
               to_hunt = 1'b1;
            end
         end
         PH_TEXT: begin
            if (limit_hit) begin
               cmd_in.slot[0].abort = 1'b1;
               to_hunt = 1'b1;
            end else begin
               tc_in = tc_ff + TCW'(1);
               if (is_end) begin
                  // flush delayed bytes ahead of the end mark
                  case (fill_ff)
                     2'd0: begin
                        cmd_in.slot[0].valid = 1'b1;
                        cmd_in.slot[0].data  = rx;
                        cmd_in.cnt = 2'd1;
                     end
                     2'd1: begin
                        cmd_in.slot[0].valid = 1'b1;
                        cmd_in.slot[0].data  = d0_ff;
                        cmd_in.slot[1].valid = 1'b1;
                        cmd_in.slot[1].data  = rx;
                        cmd_in.cnt = 2'd2;
                     end
                     default: begin
                        cmd_in.slot[0].valid = 1'b1;
                        cmd_in.slot[0].data  = d0_ff;
                        cmd_in.slot[1].valid = 1'b1;
                        cmd_in.slot[1].data  = d1_ff;
                        cmd_in.slot[2].valid = 1'b1;
                        cmd_in.slot[2].data  = rx;
                        cmd_in.cnt = 2'd3;
                     end
                  endcase
                  fill_in = 2'd0;
               end else if (del_ok) begin
                  // missed end: delayed bytes were the CRC
                  cmd_in.slot[0].valid = 1'b1;
                  cmd_in.slot[0].data  = d0_ff;
                  cmd_in.slot[0].kind  = KIND_CRC1;
                  cmd_in.slot[1].valid = 1'b1;
                  cmd_in.slot[1].data  = d1_ff;
                  cmd_in.slot[1].kind  = KIND_CRC2;
                  cmd_in.slot[2].done  = 1'b1;
                  cmd_in.cnt = 2'd3;
                  to_hunt = 1'b1;
               end else if (fill_ff == 2'd2) begin
                  cmd_in.slot[0].valid = 1'b1;
                  cmd_in.slot[0].data  = d0_ff;
                  d0_in = d1_ff;
                  d1_in = rx;
               end else begin
                  if (fill_ff == 2'd0) d0_in = rx;
                  else                 d1_in = rx;
                  fill_in = fill_ff + 2'd1;
               end
            end
         end
         PH_CRC1: begin
            cmd_in.slot[0].valid = 1'b1;
            cmd_in.slot[0].data  = rx;
            cmd_in.slot[0].kind  = KIND_CRC1;
         end
         PH_CRC2: begin
            cmd_in.slot[0].valid = 1'b1;
            cmd_in.slot[0].data  = rx;
            cmd_in.slot[0].kind  = KIND_CRC2;
         end
         PH_TAIL: begin
            cmd_in.slot[0].done = 1'b1;
            to_hunt = 1'b1;
         end
         default: to_hunt = 1'b1;
      endcase
      if (to_hunt) begin
         rc_in   = 8'sd0;
         tc_in   = '0;
         fill_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmr_ff   <= RST_PREAMBLE_MIN_RUN;
         inv_ff   <= RST_INVERT_RUN;
         mtl_ff   <= RST_MAX_TEXT_LEN;
         mhl_ff   <= RST_MIN_HEADER_LEN;
         phase_ff <= PH_HUNT;
         rc_ff    <= 8'sd0;
         tc_ff    <= '0;
         fill_ff  <= 2'd0;
      end else begin
         if (csr_we) begin
            unique case (abf_csr_type'(csr_index))
               CSR_PREAMBLE_MIN_RUN: pmr_ff <= csr_wdata[6:0];
               CSR_INVERT_RUN:       inv_ff <= csr_wdata[4:0];
               CSR_MAX_TEXT_LEN:     mtl_ff <= csr_wdata[8:0];
               CSR_MIN_HEADER_LEN:   mhl_ff <= csr_wdata[6:0];
               default:              ;
            endcase
         end
         if (accept) begin
            phase_ff <= phase_in;
            rc_ff    <= rc_in;
            tc_ff    <= tc_in;
            fill_ff  <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d0_ff <= d0_in;
         d1_ff <= d1_in;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("delay fill out of range");

endmodule

`default_nettype wire

// ===== sv/abf_queue.sv =====
// ----------------------------------------------------------------------------
// abf_queue
// Short queue of command items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire abf_pkg::abf_cmd_type  din,
   input  wire logic                  pop,
   output      abf_pkg::abf_cmd_type  dout,
   output      logic                  full,
   output      logic                  empty
);
   import abf_pkg::*;

   abf_cmd_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= din;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== sv/abf_back.sv =====
// ----------------------------------------------------------------------------
// abf_back
// Unpacks command items into one to three result items and drives the
// result stream through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module abf_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire abf_pkg::abf_cmd_type  q_head,
   output      logic                  q_pop,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [15:0]           rsp_tdata,
   output      logic [2:0]            rsp_tuser,
   output      logic                  rsp_tlast
);
   import abf_pkg::*;

   abf_cmd_type   cmd_ff, cmd_in;
   logic          cmd_valid_ff, cmd_valid_in;
   logic [1:0]    idx_ff, idx_in;
   logic          out_valid_ff, out_valid_in;
   abf_slot_type  out_slot_ff;
   logic [3:0]    out_nbits_ff;
   logic          out_flip_ff;
   logic          out_last_ff;

   abf_slot_type  slot_cur;
   logic          advance, emit, last_slot, cmd_free;

   assign slot_cur  = cmd_ff.slot[idx_ff];
   assign last_slot = (idx_ff + 2'd1) == cmd_ff.cnt;
   assign advance   = !out_valid_ff || rsp_tready;
   assign emit      = advance && cmd_valid_ff;
   assign cmd_free  = !cmd_valid_ff || (emit && last_slot);
   assign q_pop     = cmd_free && !q_empty;

   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cmd_in       = q_head;
         cmd_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (emit) begin
         if (last_slot) cmd_valid_in = 1'b0;
         idx_in = idx_ff + 2'd1;
      end
      out_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         out_slot_ff  <= slot_cur;
         out_nbits_ff <= cmd_ff.nbits;
         out_flip_ff  <= cmd_ff.flip;
         out_last_ff  <= last_slot;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_slot_ff.abort, out_slot_ff.done, out_slot_ff.start,
                        out_slot_ff.data, out_flip_ff, out_nbits_ff};
   assign rsp_tuser  = {out_slot_ff.kind, out_slot_ff.valid};
   assign rsp_tlast  = out_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff |-> (cmd_ff.cnt != 2'd0 && idx_ff < cmd_ff.cnt))
      else $error("result index beyond item count");

endmodule

`default_nettype wire

// ===== sv/acars_byte_framer.sv =====
// Path: an accepted byte goes through the queue, the back's command register
// and the output register. Throughput: one byte per cycle while the 4-entry
// queue has room; each byte gives 1 to 3 results, and the result port sends
// one per cycle while rsp_tready is high.
// Reset: synchronous, active high; hunting phase, counters cleared, registers
// back to their defaults, queue and output empty.
// ----------------------------------------------------------------------------
// acars_byte_framer
// Byte-level frame sync and deframer: preamble hunt, bit slip, sync check,
// delayed text streaming, CRC bytes and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module acars_byte_framer #(
   parameter int TEXT_LIMIT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,    // [3:0] next_bits, [4] flip_polarity,
                                          // [12:5] data_byte, [13] frame_start,
                                          // [14] frame_done, [15] frame_abort
   output      logic [2:0]  rsp_tuser,    // [0] data_valid, [2:1] data_kind
   output      logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);
   import abf_pkg::*;

   logic         push, pop, q_full, q_empty;
   abf_cmd_type  cmd_push, cmd_head;

   abf_front #(
      .TEXT_LIMIT (TEXT_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .cmd        (cmd_push),
      .q_full     (q_full)
   );

   abf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (cmd_push),
      .pop   (pop),
      .dout  (cmd_head),
      .full  (q_full),
      .empty (q_empty)
   );

   abf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (cmd_head),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
